>>> rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants for the modular exponentiation core.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned ValW = 31;
  localparam int unsigned ExpW = 63;
  localparam int unsigned AddrW = 2;

  localparam logic [ValW-1:0] ModulusReset = 31'd998244353;
  localparam logic [AddrW-1:0] RegModulus = 2'd0;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StMulRes,
    StMulSq,
    StDone
  } modexp_state_e;

endpackage

>>> rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial modular multiplier: (a * b) mod m by interleaved shift-add,
// one multiplier bit per cycle, MSB first. Operands must be below m.
// ----------------------------------------------------------------------------
module modexp_mulmod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [modexp_pkg::ValW-1:0]   a_i,
  input  logic [modexp_pkg::ValW-1:0]   b_i,
  input  logic [modexp_pkg::ValW-1:0]   m_i,
  output logic                          done_o,
  output logic [modexp_pkg::ValW-1:0]   p_o
);
  import modexp_pkg::*;

  localparam int unsigned CntW = $clog2(ValW + 1);

  logic [ValW-1:0] acc_q, acc_d, a_q, b_q, b_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [ValW+1:0] dbl, dbl_r, add, add_r;

  // one step: acc = 2*acc mod m, then + a mod m if bit set
  always_comb begin
    dbl   = {1'b0, acc_q, 1'b0};
    dbl_r = (dbl >= {2'b00, m_i}) ? dbl - {2'b00, m_i} : dbl;
    add   = dbl_r + (b_q[ValW-1] ? {2'b00, a_q} : '0);
    add_r = (add >= {2'b00, m_i}) ? add - {2'b00, m_i} : add;
  end

  always_comb begin
    acc_d  = acc_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      b_d    = b_i;
      cnt_d  = CntW'(ValW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = add_r[ValW-1:0];
      b_d   = {b_q[ValW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
    if (start_i) a_q <= a_i;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

>>> rtl/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Right-to-left square and multiply, base^exponent mod modulus.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i, in_stall_o, base_i, exponent_i | request in
//  out     | out_valid_o, out_stall_i, power_mod_o      | result out
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata    | APB register
//
// A request runs through one serial modular multiplier (shift-add, then a
// done strobe), which first reduces the base; then each exponent bit goes
// through a check state, a multiply (set bits only) and a square. The scan
// stops early once the remaining exponent is zero. Reset loads the modulus
// with 998244353. in_stall_o is high from acceptance until the result is taken.
// ----------------------------------------------------------------------------
module modular_exponentiation_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [modexp_pkg::ValW-1:0]         base_i,
  input  logic [modexp_pkg::ExpW-1:0]         exponent_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [modexp_pkg::ValW-1:0]         power_mod_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [modexp_pkg::AddrW-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import modexp_pkg::*;

  modexp_state_e   state_q, state_d;
  logic [ValW-1:0] mod_q, res_q, res_d, sq_q, sq_d;
  logic [ExpW-1:0] exp_q, exp_d;
  logic            red_q, red_d;
  logic            mul_start;
  logic [ValW-1:0] mul_a, mul_b, mul_p;
  logic            mul_done;
  logic            accept;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == RegModulus) ? {1'b0, mod_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mod_q <= ModulusReset;
    else if (psel && penable && pwrite && paddr == RegModulus)
      mod_q <= pwdata[ValW-1:0];
  end

  assign accept = in_valid_i && !in_stall_o;

  // shared multiplier; the first pass reduces the base (base*1 mod m)
  modexp_mulmod u_mulmod (
    .clk_i, .rst_ni,
    .start_i(mul_start), .a_i(mul_a), .b_i(mul_b), .m_i(mod_q),
    .done_o(mul_done), .p_o(mul_p)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (accept) state_d = StCheck;
      StCheck: begin
        if (mod_q < 31'd2 || exp_q == '0) state_d = StDone;
        else state_d = red_q ? StMulSq : (exp_q[0] ? StMulRes : StMulSq);
      end
      StMulRes: if (mul_done) state_d = StMulSq;
      StMulSq:  if (mul_done) state_d = StCheck;
      StDone:   if (!out_stall_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // datapath and multiplier control
  always_comb begin
    res_d = res_q;
    sq_d  = sq_q;
    exp_d = exp_q;
    red_d = red_q;
    mul_start = 1'b0;
    mul_a = sq_q;
    mul_b = sq_q;
    case (state_q)
      StIdle: if (accept) begin
        sq_d  = base_i;
        exp_d = exponent_i;
        red_d = 1'b1;
        res_d = (mod_q < 31'd2) ? '0 : ValW'(1);
      end
      StCheck: begin
        if (!(mod_q < 31'd2 || exp_q == '0)) begin
          mul_start = 1'b1;
          if (red_q) begin
            // reduce base: multiplicand must be below m, so use the bit-serial
            // form with multiplicand = 1 and the base as multiplier, shifted into acc
            mul_a = ValW'(1);
            mul_b = sq_q;
          end else if (exp_q[0]) begin
            mul_a = res_q;
            mul_b = sq_q;
          end
        end
      end
      StMulRes: if (mul_done) begin
        res_d = mul_p;
        mul_start = 1'b1;
      end
      StMulSq: if (mul_done) begin
        sq_d = mul_p;
        if (red_q) red_d = 1'b0;
        else exp_d = exp_q >> 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    sq_q  <= sq_d;
    exp_q <= exp_d;
    red_q <= red_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StDone);
  assign power_mod_o = res_q;

  // result stays below the modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mod_q >= 31'd2 |-> res_q < mod_q)
    else $error("result not reduced");
  // multiplier finishes only in a multiply state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == StMulRes || state_q == StMulSq))
    else $error("stray multiplier completion");
  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(power_mod_o))
    else $error("result dropped");

endmodule

>>> sim/modexp_checker.sv
// ----------------------------------------------------------------------------
// modexp_checker
// Watches the request and result channels, predicts each power_mod from
// the accepted request and the current modulus, and compares in order.
// ----------------------------------------------------------------------------
module modexp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [modexp_pkg::ValW-1:0]   base_i,
  input  logic [modexp_pkg::ExpW-1:0]   exponent_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [modexp_pkg::ValW-1:0]   power_mod_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [modexp_pkg::AddrW-1:0]  paddr_i,
  input  logic [31:0]                   pwdata_i,
  input  logic                          pready_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import modexp_pkg::*;

  logic [ValW-1:0] modulus_q;
  logic [ValW-1:0] pred_mem[16];
  logic [3:0]      wr_ptr_q;
  logic [3:0]      rd_ptr_q;
  int              count_q;
  logic            push;
  logic            pop;

  // Right-to-left square and multiply
  function automatic logic [ValW-1:0] predict_power(logic [ValW-1:0] b,
                                                    logic [ExpW-1:0] e,
                                                    logic [ValW-1:0] m);
    logic [63:0] sq;
    logic [63:0] acc;
    logic [63:0] mm;
    logic [ExpW-1:0] rest;
    sq = {33'd0, b};
    acc = 64'd1;
    mm = {33'd0, m};
    rest = e;
    if (m < 2) return '0;
    while (rest != 0) begin
      if (rest[0]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
      rest = rest >> 1;
    end
    return acc[ValW-1:0];
  endfunction

  assign pending_o = count_q;
  assign push = in_valid_i && !in_stall_i;
  assign pop  = out_valid_i && !out_stall_i && (count_q != 0);

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
      fail_count_o <= 0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= 0;
    end else begin
      // register write
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == RegModulus)
        modulus_q <= pwdata_i[ValW-1:0];
      // accepted request
      if (push) begin
        pred_mem[wr_ptr_q] <= predict_power(base_i, exponent_i, modulus_q);
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      count_q <= count_q + (push ? 1 : 0) - (pop ? 1 : 0);
      // accepted result
      if (out_valid_i && !out_stall_i) begin
        if (count_q == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, power_mod_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (pred_mem[rd_ptr_q] !== power_mod_i) begin
            $display("%0t: power_mod mismatch, expected %0d, actual %0d",
                     $time, pred_mem[rd_ptr_q], power_mod_i);
            fail_count_o <= fail_count_o + 1;
          end
          rd_ptr_q <= rd_ptr_q + 1'b1;
        end
      end
    end
  end
endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives requests and modulus writes into the exponentiation core with
// random gaps and result stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import modexp_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int DrainWait = 4200;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [ValW-1:0] base_i = '0;
  logic [ExpW-1:0] exponent_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [ValW-1:0] power_mod_o;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;
  int              fail_count;
  int              pending;
  int              cycle_count = 0;

  always #5 clk_i = ~clk_i;

  modular_exponentiation_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .base_i, .exponent_i,
    .out_valid_o, .out_stall_i, .power_mod_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  modexp_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .base_i, .exponent_i,
    .out_valid_i(out_valid_o), .out_stall_i, .power_mod_i(power_mod_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result stall: random hold per result
  initial begin : stall_gen
    int hold;
    forever begin
      hold = $urandom_range(0, 8);
      out_stall_i <= (hold != 0);
      repeat (hold) @(posedge clk_i);
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Write the modulus through a setup and an access phase
  task automatic write_modulus(logic [ValW-1:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= RegModulus; pwdata <= {1'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Send one request after a random gap
  task automatic send_request(logic [ValW-1:0] b, logic [ExpW-1:0] e);
    repeat ($urandom_range(0, 8)) @(posedge clk_i);
    in_valid_i <= 1'b1; base_i <= b; exponent_i <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [ExpW-1:0] rand_exp();
    logic [ExpW-1:0] e;
    e = ExpW'({$urandom, $urandom});
    // half short exponents (8 or 32 bits), half full width
    case ($urandom_range(0, 3))
      0: e = e & 63'hFF;
      1: e = e & 63'hFFFF_FFFF;
      default: ;
    endcase
    return e;
  endfunction

  initial begin : stimulus
    logic [ValW-1:0] mods[6];
    mods = '{31'd2, 31'h7FFF_FFFF, 31'd3, 31'd1000000007, 31'd65536, 31'd998244353};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset modulus, field extremes, zero exponent, large base
    send_request('0, '0);
    send_request('1, '0);
    send_request('1, '1);
    send_request('0, 63'd5);
    send_request(31'd998244353, 63'd3);
    send_request(31'd2, 63'd10);
    send_request(31'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
    send_request(31'h2AAA_AAAA, 63'h5555_5555_5555_5555);
    wait_idle();
    // Out of range moduli give zero
    write_modulus(31'd0);
    send_request(31'd7, 63'd0);
    send_request(31'd7, 63'd9);
    wait_idle();
    write_modulus(31'd1);
    send_request(31'd7, 63'd0);
    wait_idle();

    // Random phases over several moduli, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 6) write_modulus(mods[ph]);
      else write_modulus(ValW'($urandom_range(2, 32'h7FFF_FFFF)));
      for (int i = 0; i < 20; i++)
        send_request(ValW'($urandom), rand_exp());
      wait_idle();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
